FILE: rtl/hds_pkg.sv
// Shared constants, codes and types of the heat diffusion stencil block.
`timescale 1ns / 1ps
`default_nettype none
package hds_pkg;

   // Grid geometry. Cell (col, row) lives at row * GRID_W + col.
   localparam int GRID_W   = 32;
   localparam int GRID_H   = 32;
   localparam int CELLS    = GRID_W * GRID_H;
   localparam int ADDR_W   = $clog2(CELLS);
   localparam int COL_W    = $clog2(GRID_W);
   localparam int ROW_W    = $clog2(GRID_H);

   // Field and arithmetic widths.
   localparam int CELL_W   = 15;
   localparam int CELL_MAX = 32767;
   localparam int RATE_W   = 15;
   localparam int CNT_W    = 8;
   localparam int CMD_W    = 2;
   localparam int IDX_W    = 5;
   localparam int LAP_W    = CELL_W + 3;
   localparam int PROD_W   = RATE_W + 1 + LAP_W;
   localparam int FRAC_W   = 16;

   // Configuration port.
   localparam int PADDR_W  = 4;
   localparam int PDATA_W  = 32;

   // Reset values of the configuration registers.
   localparam logic [RATE_W-1:0] RATE_RESET  = RATE_W'(6554);
   localparam logic [CELL_W-1:0] EDGE_RESET  = CELL_W'(1279);
   localparam logic [CNT_W-1:0]  SWEEP_RESET = CNT_W'(10);

   typedef enum logic [CMD_W-1:0] {
      CMD_INIT  = 2'd0,
      CMD_SWEEP = 2'd1,
      CMD_READ  = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      REG_RATE  = 2'd0,
      REG_EDGE  = 2'd1,
      REG_SWEEP = 2'd2,
      REG_NONE  = 2'd3
   } reg_type;

   // Stencil taps, read in this order for every interior cell; TAP_X ends the run and reads nothing.
   typedef enum logic [2:0] {
      TAP_C = 3'd0,
      TAP_N = 3'd1,
      TAP_S = 3'd2,
      TAP_W = 3'd3,
      TAP_E = 3'd4,
      TAP_X = 3'd5
   } tap_type;

   typedef struct packed {
      logic [RATE_W-1:0] rate;
      logic [CELL_W-1:0] edge_max;
      logic [CNT_W-1:0]  sweeps;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             rd_en;
      tap_type          rd_tap;
      logic             rd_bank;
      logic             acc_en;
      logic             acc_first;
      logic             mul_en;
      logic             wr_en;
      logic             wr_init;
      logic             wr_bank;
      logic             load_out;
      logic             out_use_rd;
   } dp_cmd_type;

endpackage
`default_nettype wire

FILE: rtl/hds_req_if.sv
// Command channel: one word carries a command and a cell position.
`timescale 1ns / 1ps
`default_nettype none
interface hds_req_if import hds_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic [IDX_W-1:0] col;
   logic [IDX_W-1:0] row;

   modport source (output valid, command, col, row, input ready);
   modport sink (input valid, command, col, row, output ready);
endinterface
`default_nettype wire

FILE: rtl/hds_rsp_if.sv
// Completion channel: one word per finished command.
`timescale 1ns / 1ps
`default_nettype none
interface hds_rsp_if import hds_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CELL_W-1:0] cell_value;
   logic [CMD_W-1:0]  done_kind;

   modport source (output valid, cell_value, done_kind, input ready);
   modport sink (input valid, cell_value, done_kind, output ready);
endinterface
`default_nettype wire

FILE: rtl/hds_csr.sv
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps
`default_nettype none
module hds_csr import hds_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output logic      [PDATA_W-1:0] prdata,
   output logic                    pready,
   output cfg_type                 cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;
   reg_type reg_sel;
   logic    wr_stb;

   assign reg_sel = reg_type'(paddr[3:2]);
   assign pready  = 1'b1;
   assign wr_stb  = psel && penable && pwrite;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_stb) begin
         unique case (reg_sel)
            REG_RATE:  cfg_in.rate     = pwdata[RATE_W-1:0];
            REG_EDGE:  cfg_in.edge_max = pwdata[CELL_W-1:0];
            REG_SWEEP: cfg_in.sweeps   = pwdata[CNT_W-1:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rate     <= RATE_RESET;
         cfg_ff.edge_max <= EDGE_RESET;
         cfg_ff.sweeps   <= SWEEP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read back.
   always_comb begin
      unique case (reg_sel)
         REG_RATE:  prdata = PDATA_W'(cfg_ff.rate);
         REG_EDGE:  prdata = PDATA_W'(cfg_ff.edge_max);
         REG_SWEEP: prdata = PDATA_W'(cfg_ff.sweeps);
         default:   prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

FILE: rtl/hds_dp.sv
// Datapath: the two grid banks, the stencil accumulator, multiplier and output word.
`timescale 1ns / 1ps
`default_nettype none
module hds_dp import hds_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire cfg_type     cfg,
   input  wire dp_cmd_type  cmd,
   output logic [CELL_W-1:0] cell_value
);

   logic [CELL_W-1:0] grid_a [CELLS];
   logic [CELL_W-1:0] grid_b [CELLS];

   logic [CELL_W-1:0] rd_a_ff;
   logic [CELL_W-1:0] rd_b_ff;
   logic              rd_sel_ff;
   logic [CELL_W-1:0] rdata;

   logic [ADDR_W-1:0] ctr_addr;
   logic [ADDR_W-1:0] rd_addr;

   logic [CELL_W-1:0]        c_ff;
   logic signed [LAP_W-1:0]  lap_ff;
   logic signed [LAP_W-1:0]  lap_in;
   logic signed [PROD_W-1:0] prod_ff;
   logic [CELL_W-1:0]        out_ff;

   logic [PROD_W-1:0]          mag;
   logic [PROD_W-FRAC_W-1:0]   shifted;
   logic signed [PROD_W-FRAC_W+1:0] c_ext;
   logic signed [PROD_W-FRAC_W+1:0] d_ext;
   logic signed [PROD_W-FRAC_W+1:0] sum;
   logic [CELL_W-1:0]          new_val;

   logic [CELL_W+COL_W-1:0] mx;
   logic [CELL_W+ROW_W-1:0] my;
   logic [CELL_W-1:0]       ramp_x;
   logic [CELL_W-1:0]       ramp_y;
   logic [CELL_W-1:0]       init_val;

   // Cell address of the current position and of the tap being read.
   assign ctr_addr = ADDR_W'(int'(cmd.row) * GRID_W + int'(cmd.col));

   always_comb begin
      unique case (cmd.rd_tap)
         TAP_N:   rd_addr = ctr_addr - ADDR_W'(GRID_W);
         TAP_S:   rd_addr = ctr_addr + ADDR_W'(GRID_W);
         TAP_W:   rd_addr = ctr_addr - ADDR_W'(1);
         TAP_E:   rd_addr = ctr_addr + ADDR_W'(1);
         default: rd_addr = ctr_addr;
      endcase
   end

   // Boundary ramps; the rows take the corners.
   assign mx     = (CELL_W+COL_W)'(cfg.edge_max) * (CELL_W+COL_W)'(cmd.col);
   assign my     = (CELL_W+ROW_W)'(cfg.edge_max) * (CELL_W+ROW_W)'(cmd.row);
   assign ramp_x = CELL_W'(mx / GRID_W);
   assign ramp_y = CELL_W'(my / GRID_H);

   always_comb begin
      priority if (cmd.row == '0) begin
         init_val = ramp_x;
      end else if (cmd.row == ROW_W'(GRID_H - 1)) begin
         init_val = cfg.edge_max - ramp_x;
      end else if (cmd.col == '0) begin
         init_val = ramp_y;
      end else if (cmd.col == COL_W'(GRID_W - 1)) begin
         init_val = cfg.edge_max - ramp_y;
      end else begin
         init_val = '0;
      end
   end

   // Scale the Laplacian, truncate toward zero, add to the center and saturate.
   always_comb begin
      mag     = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
      shifted = mag[PROD_W-1:FRAC_W];
      c_ext   = $signed({{(PROD_W-FRAC_W+2-CELL_W){1'b0}}, c_ff});
      d_ext   = $signed({2'b00, shifted});
      sum     = prod_ff[PROD_W-1] ? c_ext - d_ext : c_ext + d_ext;
      if (sum < 0) begin
         new_val = '0;
      end else if (sum > CELL_MAX) begin
         new_val = CELL_W'(CELL_MAX);
      end else begin
         new_val = sum[CELL_W-1:0];
      end
   end

   // Bank memories with registered reads.
   always_ff @(posedge clock) begin
      if (cmd.wr_en && (cmd.wr_init || !cmd.wr_bank)) begin
         grid_a[ctr_addr] <= cmd.wr_init ? init_val : new_val;
      end
      if (cmd.rd_en) begin
         rd_a_ff <= grid_a[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en && (cmd.wr_init || cmd.wr_bank)) begin
         grid_b[ctr_addr] <= cmd.wr_init ? init_val : new_val;
      end
      if (cmd.rd_en) begin
         rd_b_ff <= grid_b[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_sel_ff <= 1'b0;
      end else if (cmd.rd_en) begin
         rd_sel_ff <= cmd.rd_bank;
      end
   end

   assign rdata = rd_sel_ff ? rd_b_ff : rd_a_ff;

   // Laplacian accumulator: minus four times the center, then the four neighbors.
   assign lap_in = cmd.acc_first ? -$signed({1'b0, rdata, 2'b00})
                                 : lap_ff + $signed({3'b000, rdata});

   always_ff @(posedge clock) begin
      if (cmd.acc_en) begin
         lap_ff <= lap_in;
         if (cmd.acc_first) begin
            c_ff <= rdata;
         end
      end
      if (cmd.mul_en) begin
         prod_ff <= $signed({1'b0, cfg.rate}) * lap_ff;
      end
      if (cmd.load_out) begin
         out_ff <= cmd.out_use_rd ? rdata : '0;
      end
   end

   assign cell_value = out_ff;

endmodule
`default_nettype wire

FILE: rtl/hds_ctrl.sv
// Controller: command sequencing, grid traversal, bank tracking and the completion word.
`timescale 1ns / 1ps
`default_nettype none
module hds_ctrl import hds_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire cfg_type          cfg,
   input  wire logic             req_valid,
   input  wire logic [CMD_W-1:0] req_command,
   input  wire logic [IDX_W-1:0] req_col,
   input  wire logic [IDX_W-1:0] req_row,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [CMD_W-1:0]      done_kind,
   output dp_cmd_type            cmd
);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_INIT = 7'b0000010,
      ST_TAP  = 7'b0000100,
      ST_MUL  = 7'b0001000,
      ST_WR   = 7'b0010000,
      ST_READ = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   tap_type          tap_ff, tap_in;
   logic [CNT_W-1:0] iter_ff, iter_in;
   logic             bank_ff, bank_in;
   cmd_type          kind_ff, kind_in;
   logic             oob_ff, oob_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CMD_W-1:0] done_kind_ff, done_kind_in;
   cmd_type          req_cmd;
   logic             out_free;

   assign req_cmd   = cmd_type'(req_command);
   assign req_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || rsp_ready;

   // Next state and counters.
   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      tap_in   = tap_ff;
      iter_in  = iter_ff;
      bank_in  = bank_ff;
      kind_in  = kind_ff;
      oob_in   = oob_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in = req_cmd;
               unique case (req_cmd)
                  CMD_INIT: begin
                     col_in   = '0;
                     row_in   = '0;
                     state_in = ST_INIT;
                  end
                  CMD_SWEEP: begin
                     col_in   = COL_W'(1);
                     row_in   = ROW_W'(1);
                     tap_in   = TAP_C;
                     iter_in  = '0;
                     state_in = (cfg.sweeps == '0) ? ST_DONE : ST_TAP;
                  end
                  CMD_READ: begin
                     col_in   = COL_W'(req_col);
                     row_in   = ROW_W'(req_row);
                     oob_in   = (int'(req_col) >= GRID_W) || (int'(req_row) >= GRID_H);
                     state_in = ST_READ;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_INIT: begin
            if (col_ff == COL_W'(GRID_W - 1)) begin
               col_in = '0;
               if (row_ff == ROW_W'(GRID_H - 1)) begin
                  bank_in  = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         ST_TAP: begin
            if (tap_ff == TAP_X) begin
               state_in = ST_MUL;
            end else begin
               tap_in = tap_type'(tap_ff + 3'd1);
            end
         end
         ST_MUL: state_in = ST_WR;
         ST_WR: begin
            tap_in   = TAP_C;
            state_in = ST_TAP;
            if (col_ff == COL_W'(GRID_W - 2)) begin
               col_in = COL_W'(1);
               if (row_ff == ROW_W'(GRID_H - 2)) begin
                  row_in  = ROW_W'(1);
                  bank_in = !bank_ff;
                  if (iter_ff == cfg.sweeps - CNT_W'(1)) begin
                     state_in = ST_DONE;
                  end else begin
                     iter_in = iter_ff + CNT_W'(1);
                  end
               end else begin
                  row_in = row_ff + ROW_W'(1);
               end
            end else begin
               col_in = col_ff + COL_W'(1);
            end
         end
         ST_READ: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Completion word register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      done_kind_in = done_kind_ff;
      if (state_ff == ST_DONE && out_free) begin
         rsp_valid_in = 1'b1;
         done_kind_in = kind_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bank_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bank_ff      <= bank_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      col_ff       <= col_in;
      row_ff       <= row_in;
      tap_ff       <= tap_in;
      iter_ff      <= iter_in;
      kind_ff      <= kind_in;
      oob_ff       <= oob_in;
      done_kind_ff <= done_kind_in;
   end

   // Datapath commands.
   always_comb begin
      cmd            = '0;
      cmd.col        = col_ff;
      cmd.row        = row_ff;
      cmd.rd_bank    = bank_ff;
      cmd.wr_bank    = !bank_ff;
      cmd.rd_tap     = (state_ff == ST_TAP) ? tap_ff : TAP_C;
      cmd.rd_en      = (state_ff == ST_READ) || (state_ff == ST_TAP && tap_ff != TAP_X);
      cmd.acc_en     = (state_ff == ST_TAP) && (tap_ff != TAP_C);
      cmd.acc_first  = (tap_ff == TAP_N);
      cmd.mul_en     = (state_ff == ST_MUL);
      cmd.wr_en      = (state_ff == ST_WR) || (state_ff == ST_INIT);
      cmd.wr_init    = (state_ff == ST_INIT);
      cmd.load_out   = (state_ff == ST_DONE) && out_free;
      cmd.out_use_rd = (kind_ff == CMD_READ) && !oob_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign done_kind = done_kind_ff;

endmodule
`default_nettype wire

FILE: rtl/heat_diffusion_grid_stencil.sv
// Top level of the heat diffusion grid stencil block.
`timescale 1ns / 1ps
`default_nettype none
// Holds a 32 x 32 grid of 15-bit temperatures in two banks and answers three
// commands, each with one completion word. Init writes the boundary ramps and
// zeroes the interior of both banks, one cell a cycle. Sweep runs sweep_count
// Jacobi iterations over the 30 x 30 interior; each interior cell takes five
// reads through the single bank read port, the multiply and the write back.
// Read returns one cell. A command is taken only when the previous one has
// finished, but a completion word may still wait on the output while the next
// command runs.
module heat_diffusion_grid_stencil import hds_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   hds_req_if.sink                 req_chan,
   hds_rsp_if.source               rsp_chan,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [PADDR_W-1:0] paddr,
   input  wire logic [PDATA_W-1:0] pwdata,
   output logic      [PDATA_W-1:0] prdata,
   output logic                    pready
);

   cfg_type    cfg;
   dp_cmd_type cmd;

   hds_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   hds_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_chan.valid),
      .req_command (req_chan.command),
      .req_col     (req_chan.col),
      .req_row     (req_chan.row),
      .req_ready   (req_chan.ready),
      .rsp_valid   (rsp_chan.valid),
      .rsp_ready   (rsp_chan.ready),
      .done_kind   (rsp_chan.done_kind),
      .cmd         (cmd)
   );

   hds_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd        (cmd),
      .cell_value (rsp_chan.cell_value)
   );

endmodule
`default_nettype wire
